// File: rtl/core/gdad_pkg.sv
// Shared types, constants and the month-length function for the date adder.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gdad_pkg;

   localparam int YearWidth  = 14;
   localparam int MonthWidth = 4;
   localparam int DayWidth   = 5;
   localparam int CountWidth = 15;
   localparam int YearIntWidth  = 15;   // year grows by at most about 92
   localparam int TotalWidth    = 16;   // start day + count + a full year
   localparam int QuoWidth      = 8;    // year / 100 for any year the walk can reach
   localparam int StepWidth     = 3;
   localparam int ModWidth      = 7;    // year mod 100

   localparam logic [ModWidth-1:0]    LastYearOfCentury = 7'd99;
   localparam logic [YearIntWidth-1:0] Century          = 15'd100;
   localparam logic [StepWidth-1:0]   DivFirstStep      = 3'd7;
   localparam logic [MonthWidth-1:0]  January           = 4'd1;
   localparam logic [MonthWidth-1:0]  February          = 4'd2;
   localparam logic [MonthWidth-1:0]  December          = 4'd12;

   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 24;

   typedef struct packed {
      logic load;        // capture a new start date and count
      logic div_step;    // one restoring step of year / 100
      logic doy_step;    // add the length of one earlier month
      logic walk_init;   // restart the month walk from January
      logic walk_step;   // subtract one month length
      logic out_load;    // move the finished date into the output register
   } gdad_cmd_type;

   typedef struct packed {
      logic div_last;    // the division step just requested is the final one
      logic doy_done;    // all earlier months of the start year are counted
      logic walk_done;   // the remainder fits in the current month
   } gdad_status_type;

   // Length of month m; zero for any month number outside one to twelve.
   function automatic logic [DayWidth-1:0] month_days(input logic [MonthWidth-1:0] m,
                                                      input logic leap);
      logic [DayWidth-1:0] len;
      begin
         unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

// File: rtl/core/gdad_ctrl.sv
// Sequencing state machine for the date adder: accept, divide, day-of-year, walk.
// Depends on gdad_pkg for the command and status structs.
`timescale 1ns / 1ps

module gdad_ctrl
   import gdad_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  gdad_status_type status,
   output gdad_cmd_type    cmd
);

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StDoy  = 2'd2;
   localparam logic [1:0] StWalk = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = StDoy;
         end
         StDoy: begin
            if (status.doy_done) begin
               cmd.walk_init = 1'b1;
               state_in      = StWalk;
            end else begin
               cmd.doy_step = 1'b1;
            end
         end
         StWalk: begin
            if (!status.walk_done) begin
               cmd.walk_step = 1'b1;
            end else if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)       rsp_valid_in = 1'b1;
      else if (rsp_tready)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/gdad_datapath.sv
// Datapath of the date adder: year / 100 by restoring steps, running total,
// month and year counters with incremental leap tracking, output register.
// Depends on gdad_pkg.
`timescale 1ns / 1ps

module gdad_datapath
   import gdad_pkg::*;
(
   input  logic                    clock,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  gdad_cmd_type            cmd,
   output gdad_status_type         status,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic [YearIntWidth-1:0] year_ff, year_in;
   logic [YearIntWidth-1:0] rem_ff, rem_in;     // year mod 100 once divided
   logic [QuoWidth-1:0]     quo_ff, quo_in;     // year / 100, low bits kept exact
   logic [StepWidth-1:0]    step_ff, step_in;
   logic [MonthWidth-1:0]   month_ff, month_in;
   logic [MonthWidth-1:0]   limit_ff, limit_in; // start month
   logic [TotalWidth-1:0]   total_ff, total_in;
   logic [RspDataWidth-1:0] out_ff, out_in;

   logic [YearIntWidth-1:0] trial;
   logic [ModWidth-1:0]     mod100;
   logic                    leap;
   logic [DayWidth-1:0]     len;

   assign trial  = Century << step_ff;
   assign mod100 = rem_ff[ModWidth-1:0];
   assign leap   = ((mod100[1:0] == 2'd0) && (mod100 != '0)) ||
                   ((mod100 == '0) && (quo_ff[1:0] == 2'd0));
   assign len    = month_days(month_ff, leap);

   assign status.div_last  = (step_ff == '0);
   assign status.doy_done  = (month_ff >= limit_ff);
   assign status.walk_done = (total_ff <= TotalWidth'(len));

   always_comb begin
      year_in  = year_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      month_in = month_ff;
      limit_in = limit_ff;
      total_in = total_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         year_in  = YearIntWidth'(req_tdata[13:0]);
         rem_in   = YearIntWidth'(req_tdata[13:0]);
         quo_in   = '0;
         step_in  = DivFirstStep;
         month_in = January;
         limit_in = req_tdata[17:14];
         total_in = TotalWidth'(req_tdata[22:18]) + TotalWidth'(req_tdata[37:23]);
      end else if (cmd.div_step) begin
         if (rem_ff >= trial) begin
            rem_in          = rem_ff - trial;
            quo_in[step_ff] = 1'b1;
         end
         step_in = step_ff - 1'b1;
      end else if (cmd.doy_step) begin
         total_in = total_ff + TotalWidth'(len);
         month_in = month_ff + 1'b1;
      end else if (cmd.walk_init) begin
         month_in = January;
      end else if (cmd.walk_step) begin
         total_in = total_ff - TotalWidth'(len);
         if (month_ff == December) begin
            month_in = January;
            year_in  = year_ff + 1'b1;
            if (mod100 == LastYearOfCentury) begin
               rem_in = '0;
               quo_in = quo_ff + 1'b1;
            end else begin
               rem_in = rem_ff + 1'b1;
            end
         end else begin
            month_in = month_ff + 1'b1;
         end
      end else if (cmd.out_load) begin
         out_in = {1'b0, total_ff[DayWidth-1:0], month_ff, year_ff[YearWidth-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      month_ff <= month_in;
      limit_ff <= limit_in;
      total_ff <= total_in;
      out_ff   <= out_in;
   end

   assign rsp_tdata = out_ff;

endmodule

// File: rtl/core/gregorian_date_add_days_core.sv
// Gregorian date plus a day count. One transfer on req carries a start date
// and a count; one transfer on rsp returns the date that many days later.
// An item runs through these phases before its result is registered: a load,
// eight restoring steps dividing the year by 100 (for the leap rule), a count
// of the earlier months of the start year one per cycle (start_month - 1
// months, none for month zero, 14 at most), a restart of the walk at January,
// a walk that subtracts month lengths one per cycle from January of the start
// year (about 1100 months for the largest count), and a load of the output
// register. The walk dominates. A finished date holds in the datapath while
// the output register is still occupied. A new transfer is taken as soon as
// the previous result sits in the output register, even while that result
// still waits on rsp_tready. Depends on gdad_pkg, gdad_ctrl and gdad_datapath.
`timescale 1ns / 1ps

module gregorian_date_add_days_core
   import gdad_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // start_year[13:0], start_month[17:14], start_day[22:18],
   // days_to_add[37:23], zero fill[39:38]
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // end_year[13:0], end_month[17:14], end_day[22:18], zero fill[23]
   output logic [RspDataWidth-1:0] rsp_tdata
);

   gdad_cmd_type    cmd;
   gdad_status_type status;

   // Sequencer: owns the handshakes and steps the datapath through its phases.
   gdad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: counters, running total and the output register.
   gdad_datapath u_datapath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: test/tb.sv
// Self-checking testbench for gregorian_date_add_days_core: start dates and day counts in,
// predicted end dates compared field by field with every rsp transfer.
// Depends on gdad_pkg and the core RTL only; needs no files or arguments.
`timescale 1ns / 1ps

module tb;
   import gdad_pkg::*;

   // Request fields, last field in the lowest bits to match req_tdata.
   typedef struct packed {
      logic [CountWidth-1:0] days_to_add;
      logic [DayWidth-1:0]   start_day;
      logic [MonthWidth-1:0] start_month;
      logic [YearWidth-1:0]  start_year;
   } date_req_type;

   // Result fields, last field in the lowest bits to match rsp_tdata.
   typedef struct packed {
      logic [DayWidth-1:0]   end_day;
      logic [MonthWidth-1:0] end_month;
      logic [YearWidth-1:0]  end_year;
   } date_rsp_type;

   localparam int ReqBits       = $bits(date_req_type);
   localparam int RspBits       = $bits(date_rsp_type);
   localparam int RandomItems   = 510;
   localparam int HoldOffAt     = 150;   // random item at which rsp holds off
   localparam int HoldOffCycles = 4000;  // long enough for the block to fill up
   localparam int PauseAt       = 300;   // random item before which req pauses
   localparam int QuietFirst    = 400;   // random items with no idling on either side
   localparam int QuietLast     = 449;
   localparam int DrainCycles   = 1300;  // worst-case walk plus division and month count

   // Predicts end dates and holds them in arrival order until rsp returns them.
   class date_scoreboard;
      date_rsp_type expected_dates[$];
      int unsigned  errors;

      function new();
         errors = 0;
      endfunction

      function bit is_leap(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      // Zero for any month number outside one to twelve.
      function int unsigned month_length(int unsigned m, int unsigned y);
         int unsigned lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
         if (m < 1 || m > 12) return 0;
         if (m == 2) return is_leap(y) ? 29 : 28;
         return lengths[m-1];
      endfunction

      function date_rsp_type predict_end_date(date_req_type r);
         int unsigned  yr;
         int unsigned  mo;
         int unsigned  total;
         date_rsp_type d;
         yr    = r.start_year;
         total = 0;
         // day of year of the start date, then the count
         for (mo = 1; mo < r.start_month; mo++) total += month_length(mo, yr);
         total += r.start_day + r.days_to_add;
         // walk forward from January of the start year
         mo = 1;
         while (total > month_length(mo, yr)) begin
            total -= month_length(mo, yr);
            mo++;
            if (mo > 12) begin
               mo = 1;
               yr++;
            end
         end
         d.end_year  = yr[YearWidth-1:0];
         d.end_month = mo[MonthWidth-1:0];
         d.end_day   = total[DayWidth-1:0];
         return d;
      endfunction

      function void note_request(date_req_type r);
         expected_dates.push_back(predict_end_date(r));
      endfunction

      function void check_response(date_rsp_type got);
         date_rsp_type want;
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected rsp transfer, nothing pending, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_dates.pop_front();
         if (got.end_year != want.end_year) begin
            $display("%0t: end_year mismatch, expected %0d, actual %0d",
                     $time, want.end_year, got.end_year);
            errors++;
         end
         if (got.end_month != want.end_month) begin
            $display("%0t: end_month mismatch, expected %0d, actual %0d",
                     $time, want.end_month, got.end_month);
            errors++;
         end
         if (got.end_day != want.end_day) begin
            $display("%0t: end_day mismatch, expected %0d, actual %0d",
                     $time, want.end_day, got.end_day);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;

   date_scoreboard sb;
   bit             no_idle;        // stretch with no gaps and no stalls
   bit             rsp_hold_armed; // set by the sender, cleared by the receiver

   gregorian_date_add_days_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   function automatic date_req_type make_date(int unsigned y, int unsigned m,
                                              int unsigned d, int unsigned n);
      date_req_type r;
      r.start_year  = y[YearWidth-1:0];
      r.start_month = m[MonthWidth-1:0];
      r.start_day   = d[DayWidth-1:0];
      r.days_to_add = n[CountWidth-1:0];
      return r;
   endfunction

   // Mostly legal dates; the rest spans every bit of every field.
   function automatic date_req_type random_date();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      int unsigned n;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 75)      y = $urandom_range(1, 9999);
      else if (pick < 90) y = $urandom_range(0, (1 << YearWidth) - 1);
      else                y = $urandom_range((1 << YearWidth) - 120, (1 << YearWidth) - 1);
      m = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                       : $urandom_range(0, (1 << MonthWidth) - 1);
      d = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 28)
                                       : $urandom_range(0, (1 << DayWidth) - 1);
      pick = $urandom_range(0, 99);
      // keep most counts short so the month walk stays brief
      if (pick < 40)      n = $urandom_range(0, 400);
      else if (pick < 70) n = $urandom_range(0, 5000);
      else                n = $urandom_range(0, (1 << CountWidth) - 1);
      return make_date(y, m, d, n);
   endfunction

   // Offer one item, hold it until the transfer, then idle for a random gap, which may be empty.
   task automatic send_date(input date_req_type r);
      int unsigned gap;
      req_tdata  <= ReqDataWidth'(r);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      gap = no_idle ? 0 : idle_length();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Advance one edge first so the monitor has logged the last transfer.
   task automatic wait_drained();
      @(posedge clock);
      while (sb.expected_dates.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         if (rsp_hold_armed) begin
            rsp_hold_armed = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (idle_length() + 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Monitor: log accepted requests and check accepted results.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(date_req_type'(req_tdata[ReqBits-1:0]));
         if (rsp_tvalid && rsp_tready)
            sb.check_response(date_rsp_type'(rsp_tdata[RspBits-1:0]));
      end
   end

   initial begin
      sb             = new();
      no_idle        = 1'b0;
      rsp_hold_armed = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, leap rule, month and day corner cases.
      send_date(make_date(1, 1, 1, 0));
      send_date(make_date(9999, 12, 31, 1));          // roll into the next year
      send_date(make_date(2024, 2, 28, 1));           // leap year, divisible by 4
      send_date(make_date(1900, 2, 28, 1));           // century, not leap
      send_date(make_date(2000, 2, 28, 1));           // divisible by 400, leap
      send_date(make_date(0, 2, 28, 1));              // year zero counts as leap
      send_date(make_date(2023, 0, 15, 10));          // month zero counts no earlier months
      send_date(make_date(2023, 13, 1, 0));           // month past December, full year counted
      send_date(make_date(2024, 15, 31, 100));
      send_date(make_date(2023, 2, 31, 0));           // day past month end rolls forward
      send_date(make_date(2023, 4, 31, 0));
      send_date(make_date(2023, 0, 0, 0));            // zero running total
      send_date(make_date(2023, 1, 0, 0));
      send_date(make_date(2023, 6, 0, 0));
      send_date(make_date(1, 1, 1, 32000));
      send_date(make_date(9999, 12, 31, 32767));      // largest count
      send_date(make_date(16383, 12, 31, 1));         // year counter wraps on output
      send_date(make_date(16383, 15, 31, 32767));
      send_date(make_date(16300, 3, 1, 32767));
      send_date(make_date(2024, 12, 31, 366));
      send_date(make_date(2100, 3, 1, 365));
      send_date(make_date(1234, 7, 17, 12345));
      req_tvalid <= 1'b0;
      wait_drained();

      for (int i = 0; i < RandomItems; i++) begin
         if (i == HoldOffAt) rsp_hold_armed = 1'b1;
         if (i == PauseAt) begin
            // hold the sender until every pending result is back
            req_tvalid <= 1'b0;
            wait_drained();
         end
         no_idle = (i >= QuietFirst && i <= QuietLast);
         send_date(random_date());
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.expected_dates.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, sb.expected_dates.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog: several times the slowest legal run.
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/gdad_pkg.sv
rtl/core/gdad_ctrl.sv
rtl/core/gdad_datapath.sv
rtl/core/gregorian_date_add_days_core.sv
test/tb.sv
